### hdl/comdr_pkg.sv
package comdr_pkg;

  // Item codes
  localparam logic OP_ACCUM   = 1'b0;
  localparam logic OP_CORRECT = 1'b1;

  // Axis select for the shared divider
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [63:0] MOM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MOM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [31:0]        S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]        S32_MIN = 32'h8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic       prod_load;   // register products of an accumulate item
    logic       accum;       // add products and mass into the sums
    logic       clear_sums;  // start sums from zero on this add
    logic       corr_load;   // compute and register a corrected item
    logic       zero_drift;  // total mass was zero: drift 0, flag set
    logic       div_start;   // launch division for the selected axis
    logic       drift_we;    // capture divider result into drift
    logic [1:0] axis;        // axis under division
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mass_zero;  // running mass total is zero
    logic div_done;   // divider result valid this cycle
  } dp_sts_t;

  // Signed 64-bit add, saturating on overflow
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? MOM_MIN : MOM_MAX;
    end
    return s;
  endfunction

  // v - d saturated to 32 bits; bit 32 of the result is the clip flag
  function automatic logic [32:0] sat_sub32(input logic signed [31:0] v,
                                            input logic signed [31:0] d);
    logic signed [32:0] r;
    r = {v[31], v} - {d[31], d};
    if (r[32] != r[31]) begin
      return {1'b1, (r[32] ? S32_MIN : S32_MAX)};
    end
    return {1'b0, r[31:0]};
  endfunction

endpackage

### hdl/comdr_div.sv
module comdr_div import comdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  // Restoring divider, one quotient bit per cycle, 64 iterations
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    shifted  = {rem_r, dvd_r[63]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = num[63];
      dvd_nxt  = num[63] ? (64'd0 - 64'(num)) : 64'(num);
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // no borrow means the divisor fits: quotient bit is one
      if (!diff[33]) begin
        rem_nxt = diff[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // Sign and saturate the 64-bit quotient
  always_comb begin
    if (neg_r) begin
      if (dvd_r[63:31] != '0) quot = S32_MIN;
      else                    quot = 32'd0 - dvd_r[31:0];
    end else begin
      if (dvd_r[63:31] != '0) quot = S32_MAX;
      else                    quot = dvd_r[31:0];
    end
  end

  assign done = done_r;

endmodule

### hdl/comdr_dp.sv
module comdr_dp import comdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic        [15:0] in_mass,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic signed [31:0] out_corr_vel_x,
  output logic signed [31:0] out_corr_vel_y,
  output logic signed [31:0] out_corr_vel_z,
  output logic               out_no_mass,
  output logic               out_clipped
);

  logic signed [47:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [47:0] prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic        [15:0] mass_r;
  logic signed [63:0] mom_x_r, mom_y_r, mom_z_r;
  logic signed [63:0] mom_x_nxt, mom_y_nxt, mom_z_nxt;
  logic        [31:0] mass_tot_r, mass_tot_nxt;
  logic signed [31:0] drift_x_r, drift_y_r, drift_z_r;
  logic signed [31:0] drift_x_nxt, drift_y_nxt, drift_z_nxt;
  logic               zero_seen_r, zero_seen_nxt;
  logic signed [31:0] corr_x_r, corr_y_r, corr_z_r;
  logic               no_mass_r, clipped_r;
  logic [32:0]        cx, cy, cz;
  logic signed [63:0] base_x, base_y, base_z;
  logic        [31:0] base_m;
  logic        [32:0] msum;
  logic signed [63:0] div_num;
  logic               div_done;
  logic signed [31:0] div_quot;

  // Stage one of an accumulate: mass times velocity per axis
  assign prod_x_nxt = 48'(in_vel_x) * 48'($signed({1'b0, in_mass}));
  assign prod_y_nxt = 48'(in_vel_y) * 48'($signed({1'b0, in_mass}));
  assign prod_z_nxt = 48'(in_vel_z) * 48'($signed({1'b0, in_mass}));

  always_ff @(posedge clk) begin
    if (cmd.prod_load) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_z_r <= prod_z_nxt;
      mass_r   <= in_mass;
    end
  end

  // Stage two: saturating sums, cleared at the start of a pass
  always_comb begin
    base_x = cmd.clear_sums ? 64'sd0 : mom_x_r;
    base_y = cmd.clear_sums ? 64'sd0 : mom_y_r;
    base_z = cmd.clear_sums ? 64'sd0 : mom_z_r;
    base_m = cmd.clear_sums ? 32'd0  : mass_tot_r;
    msum   = {1'b0, base_m} + 33'(mass_r);
    mom_x_nxt    = mom_x_r;
    mom_y_nxt    = mom_y_r;
    mom_z_nxt    = mom_z_r;
    mass_tot_nxt = mass_tot_r;
    if (cmd.accum) begin
      mom_x_nxt    = sat_add64(base_x, 64'(prod_x_r));
      mom_y_nxt    = sat_add64(base_y, 64'(prod_y_r));
      mom_z_nxt    = sat_add64(base_z, 64'(prod_z_r));
      mass_tot_nxt = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
    end
  end

  // Divider operand select
  always_comb begin
    case (cmd.axis)
      AXIS_X:  div_num = mom_x_r;
      AXIS_Y:  div_num = mom_y_r;
      AXIS_Z:  div_num = mom_z_r;
      default: div_num = mom_x_r;
    endcase
  end

  comdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (mass_tot_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Drift and zero-mass flag updates
  always_comb begin
    drift_x_nxt   = drift_x_r;
    drift_y_nxt   = drift_y_r;
    drift_z_nxt   = drift_z_r;
    zero_seen_nxt = zero_seen_r;
    if (cmd.zero_drift) begin
      drift_x_nxt   = '0;
      drift_y_nxt   = '0;
      drift_z_nxt   = '0;
      zero_seen_nxt = 1'b1;
    end
    if (cmd.div_start) begin
      zero_seen_nxt = 1'b0;
    end
    if (cmd.drift_we) begin
      case (cmd.axis)
        AXIS_X:  drift_x_nxt = div_quot;
        AXIS_Y:  drift_y_nxt = div_quot;
        AXIS_Z:  drift_z_nxt = div_quot;
        default: drift_x_nxt = drift_x_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_x_r     <= '0;
      mom_y_r     <= '0;
      mom_z_r     <= '0;
      mass_tot_r  <= '0;
      drift_x_r   <= '0;
      drift_y_r   <= '0;
      drift_z_r   <= '0;
      zero_seen_r <= 1'b0;
    end else begin
      mom_x_r     <= mom_x_nxt;
      mom_y_r     <= mom_y_nxt;
      mom_z_r     <= mom_z_nxt;
      mass_tot_r  <= mass_tot_nxt;
      drift_x_r   <= drift_x_nxt;
      drift_y_r   <= drift_y_nxt;
      drift_z_r   <= drift_z_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  // Correct item: subtract drift, saturate, register the result
  assign cx = sat_sub32(in_vel_x, drift_x_r);
  assign cy = sat_sub32(in_vel_y, drift_y_r);
  assign cz = sat_sub32(in_vel_z, drift_z_r);

  always_ff @(posedge clk) begin
    if (cmd.corr_load) begin
      corr_x_r  <= cx[31:0];
      corr_y_r  <= cy[31:0];
      corr_z_r  <= cz[31:0];
      no_mass_r <= zero_seen_r;
      clipped_r <= cx[32] | cy[32] | cz[32];
    end
  end

  assign sts.mass_zero   = (mass_tot_r == '0);
  assign sts.div_done    = div_done;
  assign out_corr_vel_x  = corr_x_r;
  assign out_corr_vel_y  = corr_y_r;
  assign out_corr_vel_z  = corr_z_r;
  assign out_no_mass     = no_mass_r;
  assign out_clipped     = clipped_r;

endmodule

### hdl/comdr_ctrl.sv
module comdr_ctrl import comdr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_opcode,
  input  logic    in_last,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE      = 4'b0001,
    S_ADD       = 4'b0010,
    S_DIV_START = 4'b0100,
    S_DIV_WAIT  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       fresh_r, fresh_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       accept;

  // Accumulate items need no output space; correct items need a free slot
  assign in_ready = (state_r == S_IDLE) &&
                    (in_opcode == OP_ACCUM || !out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    fresh_nxt     = fresh_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.axis      = axis_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_CORRECT) begin
            cmd.corr_load = 1'b1;
            out_valid_nxt = 1'b1;
            fresh_nxt     = 1'b1;
          end else begin
            cmd.prod_load = 1'b1;
            last_nxt      = in_last;
            state_nxt     = S_ADD;
          end
        end
      end
      S_ADD: begin
        cmd.accum      = 1'b1;
        cmd.clear_sums = fresh_r;
        fresh_nxt      = 1'b0;
        axis_nxt       = AXIS_X;
        state_nxt      = last_r ? S_DIV_START : S_IDLE;
      end
      S_DIV_START: begin
        if (sts.mass_zero) begin
          cmd.zero_drift = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.drift_we = 1'b1;
          if (axis_r == AXIS_Z) begin
            state_nxt = S_IDLE;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIV_START;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
      axis_r      <= AXIS_X;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/center_of_mass_drift_removal.sv
// Channel  Handshake             Payload
// in_      in_valid / in_ready   opcode, vel_x/y/z, mass, last
// out_     out_valid / out_ready corr_vel_x/y/z, no_mass, clipped
//
// Correct item: the result is registered on the edge that accepts the item.
// Accumulate item: multiply stage, then saturating add.
// Last accumulate item: then one shared radix-2 divider runs 64 iterations
// per axis, X then Y then Z; a zero mass total clears drift instead.
// Reset (rst_n low, synchronous) clears sums, drift and the zero-mass flag.
// Accumulate items are taken while a result waits on out_; correct items
// wait for a free output register.
module center_of_mass_drift_removal import comdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic        [15:0] in_mass,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_corr_vel_x,
  output logic signed [31:0] out_corr_vel_y,
  output logic signed [31:0] out_corr_vel_z,
  output logic               out_no_mass,
  output logic               out_clipped
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  comdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  comdr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_vel_z       (in_vel_z),
    .in_mass        (in_mass),
    .cmd            (cmd),
    .sts            (sts),
    .out_corr_vel_x (out_corr_vel_x),
    .out_corr_vel_y (out_corr_vel_y),
    .out_corr_vel_z (out_corr_vel_z),
    .out_no_mass    (out_no_mass),
    .out_clipped    (out_clipped)
  );

endmodule

### tb/comdr_check.sv
module comdr_check import comdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic        [15:0] in_mass,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_corr_vel_x,
  input  logic signed [31:0] out_corr_vel_y,
  input  logic signed [31:0] out_corr_vel_z,
  input  logic               out_no_mass,
  input  logic               out_clipped,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               no_mass;
    logic               clipped;
  } corr_t;

  // Corrected velocities still owed by the block, oldest first
  corr_t pending_corr[$];
  corr_t want;
  corr_t head;
  corr_t got;
  logic  clip;
  int    shown;

  // Shadow of the block's state
  logic signed [63:0] mom_x, mom_y, mom_z;
  logic        [31:0] mass_acc;
  logic signed [31:0] drift_x, drift_y, drift_z;
  logic               fresh;
  logic               massless;

  // Q16.16 velocity times Q8.8 mass, Q24.24 result
  function automatic logic signed [63:0] momentum(input logic signed [31:0] v,
                                                  input logic        [15:0] m);
    return longint'(v) * longint'({16'd0, m});
  endfunction

  // Running momentum sum, pinned at the 64-bit limits
  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] acc,
                                                 input logic signed [63:0] term);
    logic signed [64:0] wide;
    wide = {acc[63], acc} + {term[63], term};
    if (wide[64] != wide[63]) begin
      return wide[64] ? MOM_MIN : MOM_MAX;
    end
    return wide[63:0];
  endfunction

  // Momentum over mass, truncated toward zero, pinned to 32 bits
  function automatic logic signed [31:0] drift_div(input logic signed [63:0] num,
                                                   input logic        [31:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = num[63] ? -num : num;
    q = mag / {32'd0, den};
    if (num[63]) begin
      if (q >= 64'h0000_0000_8000_0000) begin
        return S32_MIN;
      end
      return -q[31:0];
    end
    if (q > 64'h0000_0000_7FFF_FFFF) begin
      return S32_MAX;
    end
    return q[31:0];
  endfunction

  // Velocity minus drift, pinned to 32 bits; clip goes sticky on saturation
  function automatic logic signed [31:0] sub_clip(input logic signed [31:0] v,
                                                  input logic signed [31:0] d,
                                                  inout logic clip_any);
    longint diff;
    diff = longint'(v) - longint'(d);
    if (diff > longint'(S32_MAX)) begin
      clip_any = 1'b1;
      return S32_MAX;
    end
    if (diff < -longint'(S32_MIN)) begin
      clip_any = 1'b1;
      return S32_MIN;
    end
    return diff[31:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mom_x = '0;
      mom_y = '0;
      mom_z = '0;
      mass_acc = '0;
      drift_x = '0;
      drift_y = '0;
      drift_z = '0;
      fresh = 1'b1;
      massless = 1'b0;
      pending_corr.delete();
      fail_count = 0;
      shown = 0;
    end else begin
      // Result side: compare against the oldest owed item
      if (out_valid && out_ready) begin
        got = '{out_corr_vel_x, out_corr_vel_y, out_corr_vel_z, out_no_mass, out_clipped};
        if (pending_corr.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            $display("%0t: result with nothing owed: vx=%h vy=%h vz=%h no_mass=%b clipped=%b",
                     $realtime, got.vx, got.vy, got.vz, got.no_mass, got.clipped);
          end
          shown++;
        end else begin
          head = pending_corr.pop_front();
          if (got !== head) begin
            fail_count++;
            if (shown < 10) begin
              $display("%0t: mismatch exp vx=%h vy=%h vz=%h no_mass=%b clipped=%b",
                       $realtime, head.vx, head.vy, head.vz, head.no_mass, head.clipped);
              $display("%0t:          got vx=%h vy=%h vz=%h no_mass=%b clipped=%b",
                       $realtime, got.vx, got.vy, got.vz, got.no_mass, got.clipped);
            end
            shown++;
          end
        end
      end

      // Input side: advance the shadow state
      if (in_valid && in_ready) begin
        if (in_opcode == OP_ACCUM) begin
          if (fresh) begin
            mom_x = '0;
            mom_y = '0;
            mom_z = '0;
            mass_acc = '0;
            fresh = 1'b0;
          end
          mom_x = sum_sat(mom_x, momentum(in_vel_x, in_mass));
          mom_y = sum_sat(mom_y, momentum(in_vel_y, in_mass));
          mom_z = sum_sat(mom_z, momentum(in_vel_z, in_mass));
          if ({1'b0, mass_acc} + {17'd0, in_mass} > {1'b0, 32'hFFFF_FFFF}) begin
            mass_acc = '1;
          end else begin
            mass_acc = mass_acc + {16'd0, in_mass};
          end
          if (in_last) begin
            if (mass_acc == '0) begin
              drift_x = '0;
              drift_y = '0;
              drift_z = '0;
              massless = 1'b1;
            end else begin
              drift_x = drift_div(mom_x, mass_acc);
              drift_y = drift_div(mom_y, mass_acc);
              drift_z = drift_div(mom_z, mass_acc);
              massless = 1'b0;
            end
          end
        end else begin
          clip = 1'b0;
          want.vx = sub_clip(in_vel_x, drift_x, clip);
          want.vy = sub_clip(in_vel_y, drift_y, clip);
          want.vz = sub_clip(in_vel_z, drift_z, clip);
          want.no_mass = massless;
          want.clipped = clip;
          pending_corr.push_back(want);
          fresh = 1'b1;
        end
      end
    end
    pending = pending_corr.size();
  end

endmodule

### tb/center_of_mass_drift_removal_tb.sv
module center_of_mass_drift_removal_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import comdr_pkg::*;

  localparam int LIMIT      = 3_000_000;  // watchdog, in clock cycles
  localparam int RAND_ITEMS = 1550;
  localparam int LONG_ATOMS = 300;        // full-scale atoms in one long pass

  localparam logic signed [31:0] ONE   = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic        [15:0] ONE_M = 16'h0100;        // 1.0 in Q8.8

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_opcode = OP_ACCUM;
  logic signed [31:0] in_vel_x = '0;
  logic signed [31:0] in_vel_y = '0;
  logic signed [31:0] in_vel_z = '0;
  logic        [15:0] in_mass = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_corr_vel_x;
  logic signed [31:0] out_corr_vel_y;
  logic signed [31:0] out_corr_vel_z;
  logic               out_no_mass;
  logic               out_clipped;
  int                 fail_count;
  int                 pending;

  int burst_left = 0;
  bit steady = 1'b0;   // no gaps between items
  int sent = 0;

  center_of_mass_drift_removal DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_vel_z       (in_vel_z),
    .in_mass        (in_mass),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_corr_vel_x (out_corr_vel_x),
    .out_corr_vel_y (out_corr_vel_y),
    .out_corr_vel_z (out_corr_vel_z),
    .out_no_mass    (out_no_mass),
    .out_clipped    (out_clipped)
  );

  comdr_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_vel_z       (in_vel_z),
    .in_mass        (in_mass),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_corr_vel_x (out_corr_vel_x),
    .out_corr_vel_y (out_corr_vel_y),
    .out_corr_vel_z (out_corr_vel_z),
    .out_no_mass    (out_no_mass),
    .out_clipped    (out_clipped),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("center_of_mass_drift_removal_tb NOT OK");
    $finish;
  end

  // Receiver: random stall modes, plus two long hold-offs to back up the block
  initial begin
    int rx_cycle;
    int mode;
    int span;
    rx_cycle = 0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 80);
      end
      span--;
      if ((rx_cycle >= 1500 && rx_cycle < 1900) || (rx_cycle >= 7000 && rx_cycle < 7300)) begin
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one item, inserting a random gap at burst boundaries
  task automatic send(input logic op, input logic signed [31:0] vx,
                      input logic signed [31:0] vy, input logic signed [31:0] vz,
                      input logic [15:0] m, input logic lst);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_vel_x  <= vx;
    in_vel_y  <= vy;
    in_vel_z  <= vz;
    in_mass   <= m;
    in_last   <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_vel();
    case ($urandom_range(0, 5))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return $urandom_range(0, 32'h0003_0000) - 32'sh0001_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 16'h0400));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int kind;
    int nacc;
    int ncorr;
    bit zero_pass;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Correct before any drift computation; mass and last are ignored
    send(OP_CORRECT, S32_MAX, S32_MIN, 0, 16'hFFFF, 1'b1);
    send(OP_CORRECT, -ONE, 1, -1, 16'h0000, 1'b0);
    // Zero total mass
    send(OP_ACCUM, S32_MAX, S32_MIN, ONE, 16'h0000, 1'b1);
    send(OP_CORRECT, S32_MIN, S32_MAX, 0, 16'hFFFF, 1'b0);
    // Full-scale pass, corrections that clip
    send(OP_ACCUM, S32_MAX, S32_MIN, S32_MAX, 16'hFFFF, 1'b0);
    send(OP_ACCUM, S32_MIN, S32_MAX, 0, 16'h0001, 1'b0);
    send(OP_ACCUM, 12345, -ONE, S32_MAX, ONE_M, 1'b1);
    send(OP_CORRECT, S32_MIN, S32_MAX, S32_MIN, 16'h0000, 1'b1);
    send(OP_CORRECT, S32_MAX, S32_MIN, 0, 16'h0000, 1'b0);
    // Accumulate after last with no correct in between keeps summing
    send(OP_ACCUM, ONE, ONE, ONE, ONE_M, 1'b1);
    send(OP_ACCUM, 3 * ONE, -ONE, 0, ONE_M, 1'b0);
    send(OP_ACCUM, -ONE, 2 * ONE, ONE, 16'h0200, 1'b1);
    send(OP_CORRECT, 0, 0, 0, 16'h0000, 1'b0);
    // Negative drift against the limits
    send(OP_ACCUM, -ONE, -ONE, -ONE, ONE_M, 1'b1);
    send(OP_CORRECT, S32_MIN, S32_MIN, S32_MIN, 16'h0000, 1'b0);
    send(OP_CORRECT, S32_MAX, S32_MAX, S32_MAX, 16'h0000, 1'b0);
    // Division truncates toward zero
    send(OP_ACCUM, -3, 3, 1, 16'h0001, 1'b0);
    send(OP_ACCUM, 0, 0, 0, 16'h0001, 1'b1);
    send(OP_CORRECT, 0, 0, 0, 16'h0000, 1'b0);

    // Random: mostly clean passes, some noise and passes missing last
    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        nacc = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
        zero_pass = ($urandom_range(0, 15) == 0);
        for (int i = 0; i < nacc; i++) begin
          send(OP_ACCUM, pick_vel(), pick_vel(), pick_vel(),
               zero_pass ? 16'h0000 : pick_mass(), i == nacc - 1);
        end
        ncorr = $urandom_range(1, 6);
        for (int i = 0; i < ncorr; i++) begin
          send(OP_CORRECT, pick_vel(), pick_vel(), pick_vel(), 16'($urandom),
               1'($urandom_range(0, 1)));
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6)) begin
          send(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, 16'($urandom),
               1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send(OP_ACCUM, pick_vel(), pick_vel(), pick_vel(), pick_mass(), 1'b0);
        end
        repeat ($urandom_range(1, 3)) begin
          send(OP_CORRECT, pick_vel(), pick_vel(), pick_vel(), 16'($urandom), 1'b0);
        end
      end
    end

    // Long pass of full-scale atoms back to back: large sums, drift at the limits
    steady = 1'b1;
    for (int i = 0; i < LONG_ATOMS; i++) begin
      send(OP_ACCUM, S32_MAX, S32_MIN, $urandom, 16'hFFFF, i == LONG_ATOMS - 1);
    end
    steady = 1'b0;
    send(OP_CORRECT, S32_MIN, S32_MAX, pick_vel(), 16'h0000, 1'b0);
    send(OP_CORRECT, S32_MAX, S32_MIN, 0, 16'h0000, 1'b0);
    send(OP_CORRECT, 0, 0, S32_MIN, 16'h0000, 1'b0);

    // Drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("center_of_mass_drift_removal_tb OK");
    end else begin
      $display("center_of_mass_drift_removal_tb NOT OK");
    end
    $finish;
  end

endmodule

### center_of_mass_drift_removal.f
hdl/comdr_pkg.sv
hdl/comdr_div.sv
hdl/comdr_dp.sv
hdl/comdr_ctrl.sv
hdl/center_of_mass_drift_removal.sv
tb/comdr_check.sv
tb/center_of_mass_drift_removal_tb.sv
